[src/fpt_pkg.sv]
// Shared constants, command and status types for the frame pacing timer.
`timescale 1ns / 1ps

package fpt_pkg;

	localparam logic [63:0] NS_PER_S   = 64'd1_000_000_000;
	localparam logic [63:0] RATE_NUM   = 64'd65_536_000_000_000;
	localparam logic [9:0]  FPS_MAX    = 10'd1000;
	localparam logic [9:0]  FPS_RST    = 10'd60;
	localparam logic [15:0] ALPHA_RST  = 16'd6554;
	localparam logic [29:0] PERIOD_RST = 30'd16_666_666;
	localparam logic [45:0] RATE_RST   = 46'd3_932_160;
	localparam logic [63:0] ROUND_HALF = 64'd32768;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_QUERY   = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;
	localparam logic [1:0] FUNC_RESYNC  = 2'd3;

	localparam logic REG_TARGET_FPS = 1'b0;
	localparam logic REG_ALPHA      = 1'b1;

	localparam logic [2:0] DIV_ELAPSED = 3'd0;
	localparam logic [2:0] DIV_RATE    = 3'd1;
	localparam logic [2:0] DIV_PERIOD  = 3'd2;
	localparam logic [2:0] DIV_FT      = 3'd3;
	localparam logic [2:0] DIV_REM     = 3'd4;
	localparam logic [2:0] DIV_LAG     = 3'd5;

	localparam logic [2:0] MUL_HOLD = 3'd0;
	localparam logic [2:0] MUL_A_LO = 3'd1;
	localparam logic [2:0] MUL_A_HI = 3'd2;
	localparam logic [2:0] MUL_B_LO = 3'd3;
	localparam logic [2:0] MUL_B_HI = 3'd4;
	localparam logic [2:0] MUL_Q_LO = 3'd5;
	localparam logic [2:0] MUL_Q_HI = 3'd6;
	localparam logic [2:0] MUL_R    = 3'd7;

	localparam logic [2:0] ACC_HOLD     = 3'd0;
	localparam logic [2:0] ACC_ROUND    = 3'd1;
	localparam logic [2:0] ACC_LOAD     = 3'd2;
	localparam logic [2:0] ACC_ADD      = 3'd3;
	localparam logic [2:0] ACC_ADD_HI   = 3'd4;
	localparam logic [2:0] ACC_ADD_TAIL = 3'd5;

	localparam logic [1:0] N_HOLD   = 2'd0;
	localparam logic [1:0] N_FORCED = 2'd1;
	localparam logic [1:0] N_QUOT   = 2'd2;

	typedef struct packed {
		logic       load_item;
		logic       div_start;
		logic [2:0] div_sel;
		logic [2:0] mul_sel;
		logic [2:0] acc_op;
		logic [1:0] n_sel;
		logic       adv_wr;
		logic       avg_wr;
		logic       tick_wr;
		logic       fps_wr;
		logic       restart_wr;
		logic       nx_wr;
		logic       out_load;
	} fpt_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       forced_nz;
		logic       elapsed_pos;
		logic       dt_ok;
		logic       n_nz;
		logic       tgt_ok;
		logic       tgt_new;
		logic       late;
		logic       div_busy;
		logic       div_done;
	} fpt_sts_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

[src/frame_pacing_timer_top.sv]
// Top level of the frame pacing timer: stream ports, configuration port, controller and datapath.
// Items that need no division do not use the divider; each division runs on the shared
// divider, and a late resync that changes the rate, with four divisions, is the longest item.
// One item is worked at a time; the input is ready again the cycle after the result is loaded.
// Reset is asynchronous: state returns to 60 fps, zero times and counts, no clearing pass.
`timescale 1ns / 1ps

module frame_pacing_timer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // func, now_ns, force_count, zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [239:0] m_tdata,   // frame_count, frames_advanced, measured_rate, is_late,
	                                // lag_frames, ns_until_next, zero fill
	input  logic         cfg_wr_en,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_wr_data
);
	import fpt_pkg::*;

	fpt_cmd_t    cmd;
	fpt_sts_t    sts;
	logic [63:0] frame_count;
	logic [31:0] frames_advanced;
	logic [45:0] measured_rate;
	logic        is_late;
	logic [31:0] lag_frames;
	logic [63:0] ns_until_next;

	fpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wr_data      (cfg_wr_data),
		.in_func          (s_tdata[1:0]),
		.in_now_ns        (s_tdata[65:2]),
		.in_force_count   (s_tdata[97:66]),
		.cmd              (cmd),
		.sts              (sts),
		.frame_count      (frame_count),
		.frames_advanced  (frames_advanced),
		.measured_rate    (measured_rate),
		.is_late          (is_late),
		.lag_frames       (lag_frames),
		.ns_until_next    (ns_until_next)
	);

	assign m_tdata = {1'b0, ns_until_next, lag_frames, is_late, measured_rate,
		frames_advanced, frame_count};

endmodule

[src/fpt_div.sv]
// Radix-2 restoring divider, 64-bit dividend by 30-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module fpt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [29:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quot,
	output logic [29:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [29:0] rem_q;
	logic [29:0] dsr_q;
	logic [30:0] part;
	logic [31:0] trial;

	assign part  = {rem_q, quo_q[63]};
	assign trial = {1'b0, part} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ~trial[31]};
			rem_q <= trial[31] ? part[29:0] : trial[29:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[src/fpt_dp.sv]
// Datapath: pacing state, configuration registers, shared divider and multiplier, result register.
`timescale 1ns / 1ps

module fpt_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_wr_data,
	input  logic [1:0]       in_func,
	input  logic [63:0]      in_now_ns,
	input  logic [31:0]      in_force_count,
	input  fpt_pkg::fpt_cmd_t cmd,
	output fpt_pkg::fpt_sts_t sts,
	output logic [63:0]      frame_count,
	output logic [31:0]      frames_advanced,
	output logic [45:0]      measured_rate,
	output logic             is_late,
	output logic [31:0]      lag_frames,
	output logic [63:0]      ns_until_next
);
	import fpt_pkg::*;

	logic [9:0]  target_q;
	logic [15:0] alpha_q;
	logic [63:0] ft_q;
	logic [63:0] st_q;
	logic [63:0] lt_q;
	logic [63:0] nx_q;
	logic [9:0]  fps_q;
	logic [29:0] per_q;
	logic [45:0] avg_q;
	logic [1:0]  func_q;
	logic [63:0] now_q;
	logic [31:0] forced_q;
	logic [63:0] n_q;
	logic [31:0] adv_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;

	logic [63:0] cnt_out_q;
	logic [31:0] adv_out_q;
	logic [45:0] rate_out_q;
	logic        late_out_q;
	logic [31:0] lag_out_q;
	logic [63:0] ns_out_q;

	logic [63:0] elapsed;
	logic [63:0] lag_diff;
	logic        late;
	logic [63:0] div_dividend;
	logic [29:0] div_divisor;
	logic        div_busy;
	logic        div_done;
	logic [63:0] quot;
	logic [29:0] rem;
	logic [16:0] beta;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] mul_p;
	logic [30:0] tail;

	assign elapsed  = now_q - lt_q;
	assign lag_diff = now_q - nx_q;
	assign late     = now_q > nx_q;
	assign beta     = 17'h10000 - {1'b0, alpha_q};
	assign tail     = {1'b0, quot[29:0]} + {1'b0, per_q};

	always_comb begin
		div_dividend = elapsed;
		div_divisor  = per_q;
		case (cmd.div_sel)
			DIV_ELAPSED: begin
				div_dividend = elapsed;
				div_divisor  = per_q;
			end
			DIV_RATE: begin
				div_dividend = RATE_NUM;
				div_divisor  = elapsed[29:0];
			end
			DIV_PERIOD: begin
				div_dividend = NS_PER_S;
				div_divisor  = {20'd0, target_q};
			end
			DIV_FT: begin
				div_dividend = ft_q;
				div_divisor  = {20'd0, target_q};
			end
			DIV_REM: begin
				div_dividend = prod_q;
				div_divisor  = {20'd0, target_q};
			end
			DIV_LAG: begin
				div_dividend = lag_diff;
				div_divisor  = per_q;
			end
			default: begin
				div_dividend = elapsed;
				div_divisor  = per_q;
			end
		endcase
	end

	fpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_A_LO: begin
				op_a = {16'd0, alpha_q};
				op_b = quot[31:0];
			end
			MUL_A_HI: begin
				op_a = {16'd0, alpha_q};
				op_b = {18'd0, quot[45:32]};
			end
			MUL_B_LO: begin
				op_a = {15'd0, beta};
				op_b = avg_q[31:0];
			end
			MUL_B_HI: begin
				op_a = {15'd0, beta};
				op_b = {18'd0, avg_q[45:32]};
			end
			MUL_Q_LO: begin
				op_a = quot[31:0];
				op_b = NS_PER_S[31:0];
			end
			MUL_Q_HI: begin
				op_a = quot[63:32];
				op_b = NS_PER_S[31:0];
			end
			MUL_R: begin
				op_a = {2'd0, rem};
				op_b = NS_PER_S[31:0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_p = {32'd0, op_a} * {32'd0, op_b};

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_HOLD) begin
			prod_q <= mul_p;
		end
		case (cmd.acc_op)
			ACC_ROUND:    acc_q <= ROUND_HALF;
			ACC_LOAD:     acc_q <= prod_q;
			ACC_ADD:      acc_q <= acc_q + prod_q;
			ACC_ADD_HI:   acc_q <= acc_q + {prod_q[31:0], 32'd0};
			ACC_ADD_TAIL: acc_q <= acc_q + {33'd0, tail};
			default:      acc_q <= acc_q;
		endcase
		if (cmd.load_item) begin
			func_q   <= in_func;
			now_q    <= in_now_ns;
			forced_q <= in_force_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= FPS_RST;
			alpha_q  <= ALPHA_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_TARGET_FPS) begin
				target_q <= cfg_wr_data[9:0];
			end else begin
				alpha_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q  <= '0;
			st_q  <= '0;
			lt_q  <= '0;
			nx_q  <= '0;
			fps_q <= FPS_RST;
			per_q <= PERIOD_RST;
			avg_q <= RATE_RST;
			n_q   <= '0;
			adv_q <= '0;
		end else begin
			if (cmd.load_item) begin
				n_q   <= '0;
				adv_q <= '0;
			end else if (cmd.n_sel == N_FORCED) begin
				n_q <= {32'd0, forced_q};
			end else if (cmd.n_sel == N_QUOT) begin
				n_q <= quot;
			end
			if (cmd.adv_wr) begin
				ft_q  <= ft_q + n_q;
				adv_q <= sat32(n_q);
			end
			if (cmd.avg_wr) begin
				avg_q <= acc_q[61:16];
			end
			if (cmd.tick_wr) begin
				lt_q <= now_q;
				nx_q <= now_q + {34'd0, per_q};
			end
			if (cmd.fps_wr) begin
				fps_q <= target_q;
				per_q <= quot[29:0];
			end
			if (cmd.restart_wr) begin
				ft_q  <= '0;
				st_q  <= now_q;
				lt_q  <= now_q;
				nx_q  <= now_q;
				avg_q <= {20'd0, fps_q, 16'd0};
			end
			if (cmd.nx_wr) begin
				nx_q <= st_q + acc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cnt_out_q  <= ft_q;
			adv_out_q  <= adv_q;
			rate_out_q <= avg_q;
			late_out_q <= late;
			lag_out_q  <= late ? sat32(quot) : 32'd0;
			ns_out_q   <= late ? 64'd0 : (nx_q - now_q);
		end
	end

	assign sts.func        = func_q;
	assign sts.forced_nz   = |forced_q;
	assign sts.elapsed_pos = now_q > lt_q;
	assign sts.dt_ok       = elapsed <= NS_PER_S;
	assign sts.n_nz        = |n_q;
	assign sts.tgt_ok      = (target_q != 10'd0) && (target_q <= FPS_MAX);
	assign sts.tgt_new     = target_q != fps_q;
	assign sts.late        = late;
	assign sts.div_busy    = div_busy;
	assign sts.div_done    = div_done;

	assign frame_count     = cnt_out_q;
	assign frames_advanced = adv_out_q;
	assign measured_rate   = rate_out_q;
	assign is_late         = late_out_q;
	assign lag_frames      = lag_out_q;
	assign ns_until_next   = ns_out_q;

endmodule

[src/fpt_ctrl.sv]
// Controller state machine that sequences the datapath for each operation.
`timescale 1ns / 1ps

module fpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  fpt_pkg::fpt_sts_t sts,
	output fpt_pkg::fpt_cmd_t cmd
);
	import fpt_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DECODE  = 5'd1;
	localparam logic [4:0] S_NDIV    = 5'd2;
	localparam logic [4:0] S_ADV     = 5'd3;
	localparam logic [4:0] S_RDIV    = 5'd4;
	localparam logic [4:0] S_M1      = 5'd5;
	localparam logic [4:0] S_M2      = 5'd6;
	localparam logic [4:0] S_M3      = 5'd7;
	localparam logic [4:0] S_M4      = 5'd8;
	localparam logic [4:0] S_M5      = 5'd9;
	localparam logic [4:0] S_TICKUPD = 5'd10;
	localparam logic [4:0] S_RS_PER  = 5'd11;
	localparam logic [4:0] S_RESTART = 5'd12;
	localparam logic [4:0] S_RY_PER  = 5'd13;
	localparam logic [4:0] S_RY_Q    = 5'd14;
	localparam logic [4:0] S_RY_M1   = 5'd15;
	localparam logic [4:0] S_RY_M2   = 5'd16;
	localparam logic [4:0] S_RY_M3   = 5'd17;
	localparam logic [4:0] S_RY_D    = 5'd18;
	localparam logic [4:0] S_RY_UPD  = 5'd19;
	localparam logic [4:0] S_LAG     = 5'd20;
	localparam logic [4:0] S_LDIV    = 5'd21;
	localparam logic [4:0] S_OUT     = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       out_vld_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FUNC_TICK: begin
						if (sts.forced_nz) begin
							cmd.n_sel = N_FORCED;
							state_d   = S_ADV;
						end else if (sts.elapsed_pos) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_ELAPSED;
							state_d       = S_NDIV;
						end else begin
							state_d = S_LAG;
						end
					end
					FUNC_RESTART: begin
						if (sts.tgt_ok) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_PERIOD;
							state_d       = S_RS_PER;
						end else begin
							state_d = S_RESTART;
						end
					end
					FUNC_RESYNC: begin
						if (sts.tgt_ok && sts.tgt_new) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_PERIOD;
							state_d       = S_RY_PER;
						end else begin
							state_d = S_LAG;
						end
					end
					default: state_d = S_LAG;
				endcase
			end
			S_NDIV: begin
				if (sts.div_done) begin
					cmd.n_sel = N_QUOT;
					state_d   = S_ADV;
				end
			end
			S_ADV: begin
				if (sts.n_nz) begin
					cmd.adv_wr = 1'b1;
					if (sts.elapsed_pos && sts.dt_ok) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_RATE;
						state_d       = S_RDIV;
					end else begin
						state_d = S_TICKUPD;
					end
				end else begin
					state_d = S_LAG;
				end
			end
			S_RDIV: begin
				if (sts.div_done) begin
					cmd.acc_op  = ACC_ROUND;
					cmd.mul_sel = MUL_A_LO;
					state_d     = S_M1;
				end
			end
			S_M1: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_A_HI;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.acc_op  = ACC_ADD_HI;
				cmd.mul_sel = MUL_B_LO;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_B_HI;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.acc_op = ACC_ADD_HI;
				state_d    = S_M5;
			end
			S_M5: begin
				cmd.avg_wr = 1'b1;
				state_d    = S_TICKUPD;
			end
			S_TICKUPD: begin
				cmd.tick_wr = 1'b1;
				state_d     = S_LAG;
			end
			S_RS_PER: begin
				if (sts.div_done) begin
					cmd.fps_wr = 1'b1;
					state_d    = S_RESTART;
				end
			end
			S_RESTART: begin
				cmd.restart_wr = 1'b1;
				state_d        = S_LAG;
			end
			S_RY_PER: begin
				if (sts.div_done) begin
					cmd.fps_wr    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_FT;
					state_d       = S_RY_Q;
				end
			end
			S_RY_Q: begin
				if (sts.div_done) begin
					cmd.mul_sel = MUL_Q_LO;
					state_d     = S_RY_M1;
				end
			end
			S_RY_M1: begin
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MUL_Q_HI;
				state_d     = S_RY_M2;
			end
			S_RY_M2: begin
				cmd.acc_op  = ACC_ADD_HI;
				cmd.mul_sel = MUL_R;
				state_d     = S_RY_M3;
			end
			S_RY_M3: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_REM;
				state_d       = S_RY_D;
			end
			S_RY_D: begin
				if (sts.div_done) begin
					cmd.acc_op = ACC_ADD_TAIL;
					state_d    = S_RY_UPD;
				end
			end
			S_RY_UPD: begin
				cmd.nx_wr = 1'b1;
				state_d   = S_LAG;
			end
			S_LAG: begin
				if (sts.late) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_LAG;
					state_d       = S_LDIV;
				end else begin
					state_d = S_OUT;
				end
			end
			S_LDIV: begin
				if (sts.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_start && sts.div_busy))
		else $error("divider started while busy");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && out_vld_q && !m_tready))
		else $error("result register overwritten before it was taken");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again before the item finished");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_NDIV || state_q == S_RDIV || state_q == S_RS_PER ||
			state_q == S_RY_PER || state_q == S_RY_Q || state_q == S_RY_D ||
			state_q == S_LDIV))
		else $error("division finished while no state was waiting for it");

endmodule
